// ===== sv/bresenham_line_framebuffer_assert.svh =====
// Assertion macros for the line-drawing framebuffer block.
`ifndef BRESENHAM_LINE_FRAMEBUFFER_ASSERT_SVH
`define BRESENHAM_LINE_FRAMEBUFFER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BLF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("blf assertion failed");

// next-cycle implication, checked out of reset
`define BLF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("blf assertion failed");

`endif

// ===== sv/blf_pkg.sv =====
// Types and constants shared by the line-drawing framebuffer modules.
package blf_pkg;

	localparam int FB_DEPTH = 1024;
	localparam int FB_AW    = 10;
	localparam int BYTE_W   = 8;
	localparam int COORD_W  = 9;
	localparam int DIM_W    = 10;
	localparam int ERR_W    = 12;
	localparam int PAT_W    = 2;

	localparam logic FUNC_DRAW = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	localparam logic [PAT_W-1:0] PAT_SET   = 2'd0;
	localparam logic [PAT_W-1:0] PAT_CLEAR = 2'd1;
	localparam logic [PAT_W-1:0] PAT_DOT   = 2'd2;
	localparam logic [PAT_W-1:0] PAT_KEEP  = 2'd3;

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_READ  = 7'b0000100,
		ST_RWAIT = 7'b0001000,
		ST_PIX   = 7'b0010000,
		ST_WR    = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	typedef struct packed {
		logic clr;       // write zero at clear pointer and advance it
		logic load;      // latch the accepted word
		logic rd_byte;   // read framebuffer at latched address
		logic pix_rd;    // read byte holding current pixel
		logic pix_wr;    // write back modified byte
		logic advance;   // one Bresenham step
		logic out_read;  // load output regs with read result
		logic out_draw;  // load output regs with draw result
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic at_end;
		logic visible;
	} sts_t;

endpackage

// ===== sv/bresenham_line_framebuffer.sv =====
// Top level of the line-drawing framebuffer block.
// channel  | handshake            | word
// in       | in_valid / in_stall  | func start_x start_y end_x end_y pattern read_addr
// out      | out_valid / out_stall| read_data pixel_count
// After reset a clearing pass zeroes the framebuffer, one byte a cycle, with in_stall
// high. A read passes through ST_READ and ST_RWAIT to the result word.
// A draw visits ST_PIX for every pixel and ST_WR for each drawn one; each drawn pixel
// is a read-modify-write through the single framebuffer RAM.
// A new word is accepted while the previous result still waits on out_stall.
`include "bresenham_line_framebuffer_assert.svh"
module bresenham_line_framebuffer import blf_pkg::*; #(
	parameter int SCREEN_WIDTH  = 96,
	parameter int SCREEN_HEIGHT = 64,
	parameter int ROW_BYTES     = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      func,
	input  logic signed [COORD_W-1:0] start_x,
	input  logic signed [COORD_W-1:0] start_y,
	input  logic signed [COORD_W-1:0] end_x,
	input  logic signed [COORD_W-1:0] end_y,
	input  logic [PAT_W-1:0]          pattern,
	input  logic [FB_AW-1:0]          read_addr,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [BYTE_W-1:0]         read_data,
	output logic [DIM_W-1:0]          pixel_count
);

	cmd_t              cmd;
	sts_t              sts;
	logic              ram_we, ram_re;
	logic [FB_AW-1:0]  ram_waddr, ram_raddr;
	logic [BYTE_W-1:0] ram_wdata, ram_rdata;

	blf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	blf_datapath #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.ROW_BYTES     (ROW_BYTES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.pattern     (pattern),
		.read_addr   (read_addr),
		.read_data   (read_data),
		.pixel_count (pixel_count),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata)
	);

	blf_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (FB_DEPTH)
	) u_fb (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// the block is busy in the cycle after it takes a word
	`BLF_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	// framebuffer is never written while the input side is open
	`BLF_ASSERT_NOW(a_no_write_when_open, clk, arst_n, ram_we, in_stall)
	// a draw result never carries byte data
	`BLF_ASSERT_NOW(a_draw_word_clean, clk, arst_n, out_valid && (pixel_count != '0),
		read_data == '0)

endmodule

// ===== sv/blf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module blf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/blf_ctrl.sv =====
// Controller state machine: clearing pass, command sequencing, output handshake.
module blf_ctrl import blf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic func,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					state_d  = (func == FUNC_READ) ? ST_READ : ST_PIX;
				end
			end
			ST_READ: begin
				cmd.rd_byte = 1'b1;
				state_d     = ST_RWAIT;
			end
			ST_RWAIT: begin
				// RAM read data holds until the next read, so waiting is safe
				if (out_free) begin
					cmd.out_read = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_PIX: begin
				priority if (sts.visible) begin
					cmd.pix_rd = 1'b1;
					state_d    = ST_WR;
				end else if (sts.at_end) begin
					state_d = ST_DONE;
				end else begin
					cmd.advance = 1'b1;
				end
			end
			ST_WR: begin
				cmd.pix_wr = 1'b1;
				if (sts.at_end) begin
					state_d = ST_DONE;
				end else begin
					cmd.advance = 1'b1;
					state_d     = ST_PIX;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_draw = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			priority if (cmd.out_read || cmd.out_draw) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sv/blf_datapath.sv =====
// Datapath: Bresenham stepper, pixel read-modify-write, clear pointer, output regs.
module blf_datapath import blf_pkg::*; #(
	parameter int SCREEN_WIDTH  = 96,
	parameter int SCREEN_HEIGHT = 64,
	parameter int ROW_BYTES     = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output sts_t                      sts,
	input  logic signed [COORD_W-1:0] start_x,
	input  logic signed [COORD_W-1:0] start_y,
	input  logic signed [COORD_W-1:0] end_x,
	input  logic signed [COORD_W-1:0] end_y,
	input  logic [PAT_W-1:0]          pattern,
	input  logic [FB_AW-1:0]          read_addr,
	output logic [BYTE_W-1:0]         read_data,
	output logic [DIM_W-1:0]          pixel_count,
	output logic                      ram_we,
	output logic [FB_AW-1:0]          ram_waddr,
	output logic [BYTE_W-1:0]         ram_wdata,
	output logic                      ram_re,
	output logic [FB_AW-1:0]          ram_raddr,
	input  logic [BYTE_W-1:0]         ram_rdata
);

	logic signed [COORD_W-1:0] x_q, y_q, xe_q, ye_q;
	logic [DIM_W-1:0]          dx_q, dy_q, step_q;
	logic                      sx_neg_q, sy_neg_q;
	logic signed [ERR_W-1:0]   err_q;
	logic [PAT_W-1:0]          pat_q;
	logic [FB_AW-1:0]          addr_q, clr_q;
	logic [BYTE_W-1:0]         read_data_q;
	logic [DIM_W-1:0]          pixel_count_q;

	logic signed [DIM_W-1:0]   ddx, ddy;
	logic [DIM_W-1:0]          dx_n, dy_n;
	logic signed [ERR_W-1:0]   err_init;
	logic signed [ERR_W:0]     e2, ndy, pdx;
	logic                      mv_x, mv_y;
	logic signed [ERR_W-1:0]   err_n;
	logic                      on_screen, pix_on;
	logic [FB_AW-1:0]          pix_addr;
	logic [BYTE_W-1:0]         pix_mask;

	// set-up: absolute deltas and initial error term
	assign ddx      = DIM_W'(end_x) - DIM_W'(start_x);
	assign ddy      = DIM_W'(end_y) - DIM_W'(start_y);
	assign dx_n     = ddx[DIM_W-1] ? DIM_W'(-ddx) : DIM_W'(ddx);
	assign dy_n     = ddy[DIM_W-1] ? DIM_W'(-ddy) : DIM_W'(ddy);
	assign err_init = $signed({{(ERR_W-DIM_W){1'b0}}, dx_n})
		- $signed({{(ERR_W-DIM_W){1'b0}}, dy_n});

	// one step
	assign e2    = {err_q, 1'b0};
	assign ndy   = -$signed({{(ERR_W+1-DIM_W){1'b0}}, dy_q});
	assign pdx   = $signed({{(ERR_W+1-DIM_W){1'b0}}, dx_q});
	assign mv_x  = e2 > ndy;
	assign mv_y  = e2 < pdx;
	assign err_n = err_q
		- (mv_x ? $signed({{(ERR_W-DIM_W){1'b0}}, dy_q}) : ERR_W'(0))
		+ (mv_y ? $signed({{(ERR_W-DIM_W){1'b0}}, dx_q}) : ERR_W'(0));

	assign on_screen = !x_q[COORD_W-1] && !y_q[COORD_W-1]
		&& ({1'b0, x_q[COORD_W-2:0]} < COORD_W'(SCREEN_WIDTH))
		&& ({1'b0, y_q[COORD_W-2:0]} < COORD_W'(SCREEN_HEIGHT));

	assign pix_addr = FB_AW'(x_q[COORD_W-2:3]) + FB_AW'(y_q[5:0] * ROW_BYTES);
	assign pix_mask = BYTE_W'(1) << x_q[2:0];

	always_comb begin
		unique case (pat_q)
			PAT_SET:   pix_on = 1'b1;
			PAT_CLEAR: pix_on = 1'b0;
			PAT_DOT:   pix_on = step_q[0];
			default:   pix_on = 1'b0;
		endcase
	end

	assign sts.clr_last = (clr_q == FB_AW'(FB_DEPTH - 1));
	assign sts.at_end   = (x_q == xe_q) && (y_q == ye_q);
	assign sts.visible  = on_screen && (pat_q != PAT_KEEP);

	// framebuffer port steering
	assign ram_we    = cmd.clr || cmd.pix_wr;
	assign ram_waddr = cmd.clr ? clr_q : pix_addr;
	assign ram_wdata = cmd.clr ? BYTE_W'(0)
		: (pix_on ? (ram_rdata | pix_mask) : (ram_rdata & ~pix_mask));
	assign ram_re    = cmd.rd_byte || cmd.pix_rd;
	assign ram_raddr = cmd.rd_byte ? addr_q : pix_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr) begin
			clr_q <= clr_q + FB_AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q      <= start_x;
			y_q      <= start_y;
			xe_q     <= end_x;
			ye_q     <= end_y;
			dx_q     <= dx_n;
			dy_q     <= dy_n;
			sx_neg_q <= !(start_x < end_x);
			sy_neg_q <= !(start_y < end_y);
			err_q    <= err_init;
			step_q   <= '0;
			pat_q    <= pattern;
			addr_q   <= read_addr;
		end else if (cmd.advance) begin
			err_q  <= err_n;
			step_q <= step_q + DIM_W'(1);
			if (mv_x) begin
				x_q <= sx_neg_q ? x_q - COORD_W'(1) : x_q + COORD_W'(1);
			end
			if (mv_y) begin
				y_q <= sy_neg_q ? y_q - COORD_W'(1) : y_q + COORD_W'(1);
			end
		end
		if (cmd.out_read) begin
			read_data_q   <= ram_rdata;
			pixel_count_q <= '0;
		end else if (cmd.out_draw) begin
			read_data_q   <= '0;
			pixel_count_q <= step_q + DIM_W'(1);
		end
	end

	assign read_data   = read_data_q;
	assign pixel_count = pixel_count_q;

endmodule
